### hw/rtl/pqadc_pkg.sv
// pqadc_pkg: types and constants shared by the PQ lookup-table distance engine.
// No dependencies.
`timescale 1ns / 1ps

package pqadc_pkg;

	localparam int ADDR_W       = 16;
	localparam int TABLE_DEPTH  = 65536;
	localparam int VALUE_W      = 32;
	localparam int SUM_W        = 40;
	localparam int SEG_W        = 9;
	localparam int MAX_SEGMENTS = 256;
	localparam int BYTE_W       = 8;
	localparam int NIBBLE_W     = 4;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 9;
	localparam int OUTQ_DEPTH   = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_SEGS = CFG_INDEX_W'(1);

	localparam logic MODE_4BIT = 1'b0;
	localparam logic MODE_8BIT = 1'b1;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_CODE  = 1'b1
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic [ADDR_W-1:0]          table_index;
		logic signed [VALUE_W-1:0]  table_value;
		logic [BYTE_W-1:0]          code_byte;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] distance;
	} result_t;

	// classified operation passed from front to back
	typedef struct packed {
		logic                is_write;
		logic [ADDR_W-1:0]   addr0;
		logic [ADDR_W-1:0]   addr1;
		logic [VALUE_W-1:0]  wdata;
		logic                use1;
		logic                done;
	} op_t;

endpackage

### hw/rtl/pqadc_stream_if.sv
// pqadc_stream_if: valid/ready channel carrying one payload of type T.
// Used with pqadc_pkg::item_t and pqadc_pkg::result_t.
`timescale 1ns / 1ps

interface pqadc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pq_adc_lut_distance.sv
// pq_adc_lut_distance: PQ asymmetric distance scan over a per-query lookup table.
// Throughput: one item per cycle, table writes and code bytes alike, unless the op queue
// is full; 4-bit codes read both nibbles' entries in the same cycle on the table RAM's
// two read ports. A completing code byte passes through the op queue, a registered RAM
// read and the accumulate into the result queue before its distance is valid.
// Reset clears configuration (8-bit mode, one segment), position, sum and queues;
// the lookup table is not cleared and holds no meaning until written.
`timescale 1ns / 1ps

module pq_adc_lut_distance #(
	parameter int ENTRY_WIDTH = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pqadc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pqadc_pkg::CFG_DATA_W-1:0]  cfg_data,
	pqadc_stream_if.sink                      item,
	pqadc_stream_if.source                    result
);

	logic           f_valid;
	logic           f_ready;
	pqadc_pkg::op_t f_op;
	logic           b_valid;
	logic           b_ready;
	pqadc_pkg::op_t b_op;
	logic           clear;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_cnt;

	assign clear = cfg_we && ((cfg_index == pqadc_pkg::CFG_MODE) ||
	                          (cfg_index == pqadc_pkg::CFG_SEGS));

	pqadc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op        (f_op)
	);

	pqadc_fifo #(
		.T     (pqadc_pkg::op_t),
		.DEPTH (QUEUE_DEPTH)
	) u_opq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_op),
		.count      (q_cnt)
	);

	pqadc_back #(
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear && (q_cnt == '0)),
		.op_valid (b_valid),
		.op_ready (b_ready),
		.op       (b_op),
		.result   (result)
	);

endmodule

### hw/rtl/pqadc_ram.sv
// pqadc_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module pqadc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

### hw/rtl/pqadc_fifo.sv
// pqadc_fifo: small register queue with valid/ready on both sides and a fill count.
// No dependencies.
`timescale 1ns / 1ps

module pqadc_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  T                           push_data,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output T                           pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/pqadc_front.sv
// pqadc_front: accepts items, holds configuration and segment position,
// and turns each item into a table write or up to two table reads (pqadc_pkg).
`timescale 1ns / 1ps

module pqadc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pqadc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pqadc_pkg::CFG_DATA_W-1:0]  cfg_data,
	pqadc_stream_if.sink                      item,
	output logic                              op_valid,
	input  logic                              op_ready,
	output pqadc_pkg::op_t                    op
);

	localparam int SEG_W = pqadc_pkg::SEG_W;
	localparam int POS_W = SEG_W + 1;

	logic             mode_q;
	logic [SEG_W-1:0] eff_q;
	logic [SEG_W-1:0] pos_q;
	logic [SEG_W-1:0] pos_d;
	logic [POS_W-1:0] pos1;
	logic [POS_W-1:0] pos2;
	logic             done0;
	logic             done1;
	logic             accept;
	logic             is_code;
	logic [SEG_W-1:0] seg_in;
	logic [SEG_W-1:0] eff_d;

	assign item.ready = op_ready;
	assign op_valid   = item.valid;
	assign accept     = item.valid && op_ready;
	assign is_code    = (item.data.action == pqadc_pkg::ACT_CODE);

	assign pos1  = {1'b0, pos_q} + POS_W'(1);
	assign pos2  = {1'b0, pos_q} + POS_W'(2);
	assign done0 = (pos1 >= {1'b0, eff_q});
	assign done1 = (pos2 >= {1'b0, eff_q});

	always_comb begin
		op       = '0;
		pos_d    = pos_q;
		op.wdata = item.data.table_value;
		if (!is_code) begin
			op.is_write = 1'b1;
			op.addr0    = item.data.table_index;
		end else if (mode_q == pqadc_pkg::MODE_8BIT) begin
			op.addr0 = {pos_q[7:0], item.data.code_byte};
			op.done  = done0;
			pos_d    = done0 ? '0 : pos1[SEG_W-1:0];
		end else begin
			op.addr0 = {4'b0000, pos_q[7:0], item.data.code_byte[3:0]};
			op.addr1 = {4'b0000, pos1[7:0], item.data.code_byte[7:4]};
			if (done0) begin
				op.done = 1'b1;
				pos_d   = '0;
			end else begin
				op.use1 = 1'b1;
				op.done = done1;
				pos_d   = done1 ? '0 : pos2[SEG_W-1:0];
			end
		end
	end

	assign seg_in = cfg_data[SEG_W-1:0];
	always_comb begin
		if (seg_in == '0) begin
			eff_d = SEG_W'(1);
		end else if (seg_in > SEG_W'(pqadc_pkg::MAX_SEGMENTS)) begin
			eff_d = SEG_W'(pqadc_pkg::MAX_SEGMENTS);
		end else begin
			eff_d = seg_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pqadc_pkg::MODE_8BIT;
			eff_q  <= SEG_W'(1);
			pos_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pqadc_pkg::CFG_MODE: begin
					mode_q <= cfg_data[0];
					pos_q  <= '0;
				end
				pqadc_pkg::CFG_SEGS: begin
					eff_q <= eff_d;
					pos_q <= '0;
				end
				default: ;
			endcase
		end else if (accept && is_code) begin
			pos_q <= pos_d;
		end
	end

endmodule

### hw/rtl/pqadc_back.sv
// pqadc_back: executes queued ops against the lookup table RAM, accumulates
// the running sum and queues finished distances. Uses pqadc_pkg, pqadc_ram, pqadc_fifo.
`timescale 1ns / 1ps

module pqadc_back #(
	parameter int ENTRY_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  logic           op_valid,
	output logic           op_ready,
	input  pqadc_pkg::op_t op,
	pqadc_stream_if.source result
);

	localparam int SUM_W = pqadc_pkg::SUM_W;
	localparam int OQ_CW = $clog2(pqadc_pkg::OUTQ_DEPTH + 1);

	logic [ENTRY_WIDTH-1:0]   rdata0;
	logic [ENTRY_WIDTH-1:0]   rdata1;
	logic                     issue;
	logic                     room;
	logic                     code_s1;
	logic                     use1_s1;
	logic                     done_s1;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  e0;
	logic signed [SUM_W-1:0]  e1;
	logic signed [SUM_W-1:0]  total;
	logic                     oq_push;
	logic                     oq_push_ready;
	logic                     oq_pop;
	logic [OQ_CW-1:0]         oq_cnt;
	pqadc_pkg::result_t       oq_in;

	// a finishing op may issue only if the result queue will have room for it
	assign oq_pop = result.valid && result.ready;
	assign room   = ({1'b0, oq_cnt} + {{OQ_CW{1'b0}}, (code_s1 && done_s1)})
	                < ((OQ_CW + 1)'(pqadc_pkg::OUTQ_DEPTH) + {{OQ_CW{1'b0}}, oq_pop});
	assign op_ready = op.is_write || !op.done || room;
	assign issue    = op_valid && op_ready;

	pqadc_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (pqadc_pkg::TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.we     (issue && op.is_write),
		.waddr  (op.addr0),
		.wdata  (op.wdata[ENTRY_WIDTH-1:0]),
		.raddr0 (op.addr0),
		.raddr1 (op.addr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_s1 <= 1'b0;
			use1_s1 <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			code_s1 <= issue && !op.is_write;
			use1_s1 <= op.use1;
			done_s1 <= op.done;
		end
	end

	assign e0 = {{(SUM_W - ENTRY_WIDTH){rdata0[ENTRY_WIDTH-1]}}, rdata0};
	assign e1 = use1_s1 ? {{(SUM_W - ENTRY_WIDTH){rdata1[ENTRY_WIDTH-1]}}, rdata1} : '0;
	assign total = sum_q + e0 + e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (code_s1) begin
			sum_q <= done_s1 ? '0 : total;
		end
	end

	assign oq_push        = code_s1 && done_s1;
	assign oq_in.distance = total;

	pqadc_fifo #(
		.T     (pqadc_pkg::result_t),
		.DEPTH (pqadc_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (oq_push),
		.push_ready (oq_push_ready),
		.push_data  (oq_in),
		.pop_valid  (result.valid),
		.pop_ready  (result.ready && oq_push_ready | result.ready),
		.pop_data   (result.data),
		.count      (oq_cnt)
	);

endmodule

### tb/pq_adc_distance_checker.sv
// pq_adc_distance_checker: predicts candidate distances from the item, result and
// register channels of pq_adc_lut_distance and compares them in order.
// Depends on pqadc_pkg.
`timescale 1ns / 1ps

module pq_adc_distance_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pqadc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pqadc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              item_valid,
	input  logic                              item_ready,
	input  pqadc_pkg::item_t                  item_data,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  pqadc_pkg::result_t                result_data,
	output int                                fail_count,
	output int                                pending
);
	import pqadc_pkg::*;

	logic [VALUE_W-1:0]    lut_copy [TABLE_DEPTH];
	logic                  width_mode;
	logic [SEG_W-1:0]      seg_cfg;
	logic [SEG_W-1:0]      seg_pos;
	logic [SUM_W-1:0]      acc;
	logic [SUM_W-1:0]      pending_distances [$];

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
		input logic [SUM_W-1:0] want);
		if (fail_count < 200)
			$display("%0t %s: got %0d, expected %0d", $time, what, $signed(got),
				$signed(want));
		fail_count = fail_count + 1;
	endtask

	function automatic int unsigned segments_per_code();
		if (seg_cfg == 0)
			return 1;
		if (seg_cfg > MAX_SEGMENTS)
			return MAX_SEGMENTS;
		return seg_cfg;
	endfunction

	task automatic accumulate_segment(input logic [BYTE_W-1:0] centroid, output bit complete);
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] entry;
		if (width_mode == MODE_8BIT)
			addr = ADDR_W'(int'(seg_pos) * 256 + int'(centroid));
		else
			addr = ADDR_W'(int'(seg_pos) * 16 + int'(centroid[NIBBLE_W-1:0]));
		entry = lut_copy[addr];
		acc = acc + {{(SUM_W-VALUE_W){entry[VALUE_W-1]}}, entry};
		seg_pos = seg_pos + 1'b1;
		complete = 1'b0;
		if (seg_pos >= segments_per_code()) begin
			pending_distances.push_back(acc);
			acc = '0;
			seg_pos = '0;
			complete = 1'b1;
		end
	endtask

	task automatic absorb_item(input item_t it);
		bit done;
		if (it.action == ACT_WRITE) begin
			lut_copy[it.table_index] = it.table_value;
		end else if (width_mode == MODE_8BIT) begin
			accumulate_segment(it.code_byte, done);
		end else begin
			accumulate_segment({4'h0, it.code_byte[3:0]}, done);
			if (!done)
				accumulate_segment({4'h0, it.code_byte[7:4]}, done);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode = MODE_8BIT;
			seg_cfg = SEG_W'(1);
			seg_pos = '0;
			acc = '0;
			pending_distances.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MODE) begin
					width_mode = cfg_data[0];
					seg_pos = '0;
					acc = '0;
				end else if (cfg_index == CFG_SEGS) begin
					seg_cfg = cfg_data;
					seg_pos = '0;
					acc = '0;
				end
			end
			if (item_valid && item_ready)
				absorb_item(item_data);
			if (result_valid && result_ready) begin
				if (pending_distances.size() == 0)
					report_mismatch("distance with none pending", result_data.distance, '0);
				else if (result_data.distance !== pending_distances[0])
					report_mismatch("distance mismatch", result_data.distance,
						pending_distances[0]);
				if (pending_distances.size() != 0)
					void'(pending_distances.pop_front());
			end
			pending <= pending_distances.size();
		end
	end
endmodule

### tb/pq_adc_lut_distance_test.sv
// pq_adc_lut_distance_test: drives table writes, code bytes and register settings
// into pq_adc_lut_distance with bursty input and a stalling sink; gives the verdict.
// Depends on pqadc_pkg, pqadc_stream_if and pq_adc_distance_checker.
`timescale 1ns / 1ps

module pq_adc_lut_distance_test;
	import pqadc_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 8;

	typedef enum int {PICK_ANY, PICK_LOW, PICK_HIGH} pick_t;
	typedef enum int {PACE_OPEN, PACE_MOSTLY, PACE_SPARSE, PACE_PULSED} pace_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     fail_count;
	int                     pending;
	int unsigned            cycle_count;

	pqadc_stream_if #(.T(pqadc_pkg::item_t))   item_ch ();
	pqadc_stream_if #(.T(pqadc_pkg::result_t)) result_ch ();

	pq_adc_lut_distance u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	pq_adc_distance_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	bit          lut_loaded [TABLE_DEPTH];
	logic [7:0]  lo_cent [MAX_SEGMENTS];
	logic [7:0]  hi_cent [MAX_SEGMENTS];
	logic        cur_mode;
	int          cur_eff;
	int          seg_pos;
	int          cands_done;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		pace_t pace;
		int    span;
		int    tick;
		result_ch.ready = 1'b0;
		tick = 0;
		forever begin
			pace = pace_t'($urandom_range(3));
			span = $urandom_range(200, 20);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (pace)
					PACE_OPEN:   result_ch.ready <= 1'b1;
					PACE_MOSTLY: result_ch.ready <= ($urandom_range(3) != 0);
					PACE_SPARSE: result_ch.ready <= ($urandom_range(3) == 0);
					default:     result_ch.ready <= ((tick % 16) < 8);
				endcase
			end
		end
	end

	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_write(input int addr, input logic [VALUE_W-1:0] value);
		item_t it;
		it.action = ACT_WRITE;
		it.table_index = ADDR_W'(addr);
		it.table_value = value;
		it.code_byte = BYTE_W'($urandom);
		lut_loaded[ADDR_W'(addr)] = 1'b1;
		send_item(it);
	endtask

	function automatic bit step_segment();
		seg_pos++;
		if (seg_pos >= cur_eff) begin
			seg_pos = 0;
			cands_done++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic put_code(input logic [7:0] b);
		item_t it;
		it.action = ACT_CODE;
		it.table_index = ADDR_W'($urandom);
		it.table_value = $urandom;
		it.code_byte = b;
		send_item(it);
		if (cur_mode == MODE_8BIT)
			void'(step_segment());
		else if (!step_segment())
			void'(step_segment());
	endtask

	function automatic logic [7:0] choose(input int s, input pick_t how);
		int k;
		int c;
		k = (cur_mode == MODE_8BIT) ? 256 : 16;
		if (how == PICK_LOW)
			return lo_cent[s];
		if (how == PICK_HIGH)
			return hi_cent[s];
		repeat (3) begin
			c = $urandom_range(k - 1);
			if (lut_loaded[ADDR_W'(s * k + c)])
				return 8'(c);
		end
		return $urandom_range(1) ? lo_cent[s] : hi_cent[s];
	endfunction

	task automatic program_regs(input logic [CFG_DATA_W-1:0] mode_word,
		input logic [CFG_DATA_W-1:0] seg_word, input bit both);
		settle();
		cfg_we <= 1'b1;
		if (both) begin
			cfg_index <= CFG_MODE;
			cfg_data <= mode_word;
			@(posedge clk);
			cur_mode = mode_word[0];
		end
		cfg_index <= CFG_SEGS;
		cfg_data <= seg_word;
		@(posedge clk);
		if ($urandom_range(3) == 0) begin
			cfg_index <= CFG_INDEX_W'($urandom_range(2**CFG_INDEX_W - 1, CFG_SEGS + 1));
			cfg_data <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_eff = (seg_word == 0) ? 1 : (seg_word > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_word;
		seg_pos = 0;
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] mode_word,
		input logic [CFG_DATA_W-1:0] seg_word, input bit both, input int budget,
		input int cand_target);
		int    k;
		int    items;
		int    start;
		int    roll;
		int    s;
		bit    big_run;
		pick_t how;
		logic [3:0] lo;
		logic [3:0] hi;
		program_regs(mode_word, seg_word, both);
		k = (cur_mode == MODE_8BIT) ? 256 : 16;
		big_run = (cur_eff > 64);
		for (s = 0; s < cur_eff; s++) begin
			lo_cent[s] = 8'($urandom_range(k - 1));
			hi_cent[s] = 8'((int'(lo_cent[s]) + $urandom_range(k - 1, 1)) % k);
			// long codes: one extreme entry per segment drives the sum to its limit
			if (big_run) begin
				put_write(s * k + lo_cent[s],
					(cur_mode == MODE_8BIT) ? 32'h8000_0000 : 32'h7FFF_FFFF);
			end else begin
				put_write(s * k + lo_cent[s], $urandom);
				put_write(s * k + hi_cent[s], $urandom);
			end
		end
		items = 0;
		start = cands_done;
		how = PICK_ANY;
		while (items < budget || (cands_done - start) < cand_target) begin
			roll = $urandom_range(99);
			if (roll < 7) begin
				put_write($urandom, $urandom);
				items++;
			end else if (roll < 13 && !big_run) begin
				s = $urandom_range(cur_eff - 1);
				put_write(s * k + ($urandom_range(1) ? lo_cent[s] : hi_cent[s]), $urandom);
				items++;
			end else if (roll == 13) begin
				settle();
			end else begin
				if (seg_pos == 0) begin
					if (big_run)
						how = PICK_LOW;
					else
						how = pick_t'($urandom_range(9) < 2 ? $urandom_range(2, 1) : 0);
				end
				if (cur_mode == MODE_8BIT) begin
					put_code(choose(seg_pos, how));
				end else begin
					lo = 4'(choose(seg_pos, how));
					hi = (seg_pos + 1 >= cur_eff) ? 4'($urandom_range(15)) :
						4'(choose(seg_pos + 1, how));
					put_code({hi, lo});
				end
				items++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cur_mode = MODE_8BIT;
		cur_eff = 1;
		seg_pos = 0;
		cands_done = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 8-bit codes, one segment
		put_write(0, 32'h7FFF_FFFF);
		put_write(255, 32'h8000_0000);
		put_write(16'hFFFF, 32'hFFFF_FFFF);
		put_code(8'h00);
		put_code(8'hFF);

		// 4-bit, odd count: high nibble of the closing byte is dropped
		program_regs({8'h00, MODE_4BIT}, 9'd3, 1'b1);
		put_write(31, 32'h7FFF_FFFF);
		put_write(32, 32'h8000_0000);
		put_write(15, 32'h0000_0000);
		put_write(16, 32'h0000_0001);
		put_code(8'hF0);
		put_code(8'hA0);
		put_code(8'h0F);
		put_code(8'h50);
		put_code(8'h0F);
		// register write abandons the partial candidate
		program_regs({8'h00, MODE_8BIT}, 9'd1, 1'b1);
		put_code(8'h00);

		run_phase({8'h00, MODE_8BIT}, 9'd1, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd1, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd2, 1'b1, 15, 0);
		run_phase({8'hFF, MODE_8BIT}, 9'd2, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd3, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd6, 1'b0, 15, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd4, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd0, 1'b1, 15, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd0, 1'b1, 15, 0);
		run_phase({8'hFF, MODE_4BIT}, 9'd5, 1'b1, 15, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd7, 1'b1, 15, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd3, 1'b0, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd8, 1'b1, 15, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd16, 1'b1, 15, 0);
		run_phase({8'h00, MODE_4BIT}, 9'd33, 1'b1, 60, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd40, 1'b1, 60, 0);
		run_phase({8'h00, MODE_8BIT}, 9'd511, 1'b1, 0, 1);
		run_phase({8'h00, MODE_4BIT}, 9'd256, 1'b1, 0, 1);
		repeat (4)
			run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(12, 1)),
				$urandom_range(1), 15, 0);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
